FILE: hw/rtl/grat_pkg.sv
// Shared types, constants and helper functions for the rainfall grid block.
// Used by grat_unit and grid_rainfall_absorb_trickle_sim; depends on nothing.
`default_nettype none
package grat_pkg;

   localparam int MAX_SIDE    = 32;
   localparam int SIDE_BITS   = 6;
   localparam int RC_BITS     = $clog2(MAX_SIDE);
   localparam int CELLS       = MAX_SIDE * MAX_SIDE;
   localparam int IDX_BITS    = $clog2(CELLS);
   localparam int CNT_BITS    = IDX_BITS + 1;
   localparam int HEIGHT_BITS = 16;
   localparam int WATER_BITS  = 32;
   localparam int RAIN_BITS   = 16;
   localparam int RATE_BITS   = 21;
   localparam int STEP_BITS   = 20;
   localparam int TRK_BITS    = 17;
   localparam int RECIP_BITS  = 16;
   localparam int CSR_BITS    = 21;

   localparam logic [WATER_BITS-1:0] ONE_Q      = WATER_BITS'(65536);
   localparam logic [TRK_BITS-1:0]   ONE_T      = TRK_BITS'(65536);
   localparam logic [RECIP_BITS-1:0] RECIP3     = RECIP_BITS'(43691);
   localparam int                    RECIP_SH   = 17;
   localparam logic [STEP_BITS-1:0]  STEP_LIMIT = {STEP_BITS{1'b1}};

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] CSR_SIDE = 2'd0;
   localparam logic [1:0] CSR_RAIN = 2'd1;
   localparam logic [1:0] CSR_RATE = 2'd2;

   localparam logic [SIDE_BITS-1:0] SIDE_RST = SIDE_BITS'(32);
   localparam logic [RAIN_BITS-1:0] RAIN_RST = RAIN_BITS'(10);
   localparam logic [RATE_BITS-1:0] RATE_RST = RATE_BITS'(32768);

   typedef struct packed {
      logic [1:0]             opcode;
      logic [IDX_BITS-1:0]    cell_index;
      logic [HEIGHT_BITS-1:0] height;
   } req_type;

   typedef struct packed {
      logic [WATER_BITS-1:0] absorbed;
      logic [STEP_BITS-1:0]  step_count;
      logic                  status;
   } rsp_type;

   function automatic logic [SIDE_BITS-1:0] side_clamp(input logic [SIDE_BITS-1:0] s);
      logic [SIDE_BITS-1:0] r;
      r = s;
      if (s == '0) r = SIDE_BITS'(1);
      else if (s > SIDE_BITS'(MAX_SIDE)) r = SIDE_BITS'(MAX_SIDE);
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/grat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module grat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/grat_unit.sv
// Shared saturating adder for all water sums of the rainfall grid block.
// Depends on grat_pkg.
`default_nettype none
module grat_unit import grat_pkg::*; (
   input  wire logic [WATER_BITS-1:0] op_a,
   input  wire logic [WATER_BITS-1:0] op_b,
   output logic      [WATER_BITS-1:0] sum
);
   logic [WATER_BITS:0] full;

   always_comb begin
      full = {1'b0, op_a} + {1'b0, op_b};
      sum  = full[WATER_BITS] ? {WATER_BITS{1'b1}} : full[WATER_BITS-1:0];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/grid_rainfall_absorb_trickle_sim.sv
// Rainfall grid simulator. Load and unused items are answered from the idle state; a read
// first passes the readout state for the registered RAM read. A run first clears all water,
// absorbed and inflow entries, then finds the downhill neighbours of every cell, then for
// each time step sweeps the cells, passing a trickling cell's share to each receiving
// neighbour, and merges the inflow cell by cell; the run ends when the grid is dry or the
// step counter saturates. Everything goes through one saturating adder and one write and one
// read port per store under a single sequencer. Depends on grat_pkg, grat_ram and grat_unit.
`default_nettype none
module grid_rainfall_absorb_trickle_sim import grat_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_payload,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CSR_BITS-1:0] csr_wdata
);
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_RDOUT   = 4'd1;
   localparam logic [3:0] ST_CLEAR   = 4'd2;
   localparam logic [3:0] ST_DH_RD   = 4'd3;
   localparam logic [3:0] ST_DH_CAP  = 4'd4;
   localparam logic [3:0] ST_DH_WR   = 4'd5;
   localparam logic [3:0] ST_SW_RD   = 4'd6;
   localparam logic [3:0] ST_SW_RAIN = 4'd7;
   localparam logic [3:0] ST_SW_ABS  = 4'd8;
   localparam logic [3:0] ST_SW_DIV  = 4'd9;
   localparam logic [3:0] ST_SW_TRD  = 4'd10;
   localparam logic [3:0] ST_SW_TWR  = 4'd11;
   localparam logic [3:0] ST_MG_RD   = 4'd12;
   localparam logic [3:0] ST_MG_WR   = 4'd13;

   logic [3:0]             state_ff;
   logic [SIDE_BITS-1:0]   side_cfg_ff;
   logic [RAIN_BITS-1:0]   rain_ff;
   logic [RATE_BITS-1:0]   rate_ff;
   logic [SIDE_BITS-1:0]   side_ff;
   logic [CNT_BITS-1:0]    cells_ff;
   logic [IDX_BITS-1:0]    me_ff;
   logic [RC_BITS-1:0]     row_ff;
   logic [RC_BITS-1:0]     col_ff;
   logic [2:0]             dk_ff;
   logic [HEIGHT_BITS-1:0] nbh_ff [4];
   logic [HEIGHT_BITS-1:0] own_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic                   dry_ff;
   logic [WATER_BITS-1:0]  wcur_ff;
   logic [WATER_BITS-1:0]  amt_ff;
   logic [WATER_BITS-1:0]  absd_ff;
   logic [3:0]             mask_ff;
   logic [TRK_BITS-1:0]    trk_ff;
   logic [TRK_BITS-1:0]    share_ff;
   logic [2:0]             tk_ff;
   logic [IDX_BITS-1:0]    clr_ff;
   logic                   ran_ff;
   logic                   inside_ff;
   logic [STEP_BITS-1:0]   steps_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   accept_in;
   logic                   rsp_done;
   logic [SIDE_BITS-1:0]   side_use;
   logic [CNT_BITS-1:0]    cells_use;
   logic                   in_grid;
   logic                   last_cell;
   logic [IDX_BITS-1:0]    me_nx;
   logic [RC_BITS-1:0]     row_nx;
   logic [RC_BITS-1:0]     col_nx;
   logic [3:0]             nb_ok;
   logic [IDX_BITS-1:0]    nb_addr [4];
   logic [HEIGHT_BITS-1:0] lowest;
   logic                   have;
   logic [3:0]             new_mask;
   logic [WATER_BITS-1:0]  ua;
   logic [WATER_BITS-1:0]  ub;
   logic [WATER_BITS-1:0]  usum;
   logic [WATER_BITS-1:0]  rate_ext;
   logic [WATER_BITS-1:0]  amount;
   logic [TRK_BITS-1:0]    trk;
   logic [2:0]             cnt;
   logic [TRK_BITS+RECIP_BITS-1:0] prod;
   logic [TRK_BITS-1:0]    share;

   logic                   ter_we;
   logic [IDX_BITS-1:0]    ter_wa;
   logic [IDX_BITS-1:0]    ter_ra;
   logic [HEIGHT_BITS-1:0] ter_rd;
   logic                   wat_we;
   logic [IDX_BITS-1:0]    wat_wa;
   logic [WATER_BITS-1:0]  wat_wd;
   logic [WATER_BITS-1:0]  wat_rd;
   logic                   abs_we;
   logic [IDX_BITS-1:0]    abs_wa;
   logic [WATER_BITS-1:0]  abs_wd;
   logic [IDX_BITS-1:0]    abs_ra;
   logic [WATER_BITS-1:0]  abs_rd;
   logic                   inf_we;
   logic [IDX_BITS-1:0]    inf_wa;
   logic [WATER_BITS-1:0]  inf_wd;
   logic [IDX_BITS-1:0]    inf_ra;
   logic [WATER_BITS-1:0]  inf_rd;
   logic                   msk_we;
   logic [3:0]             msk_rd;

   assign accept_in   = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      side_use  = side_clamp(side_cfg_ff);
      cells_use = CNT_BITS'(side_use) * CNT_BITS'(side_use);
      in_grid   = {1'b0, req_payload.cell_index} < cells_use;
      last_cell = ({1'b0, me_ff} + CNT_BITS'(1)) == cells_ff;
      me_nx     = me_ff + IDX_BITS'(1);
      if (({1'b0, col_ff} + SIDE_BITS'(1)) == side_ff) begin
         col_nx = '0;
         row_nx = row_ff + RC_BITS'(1);
      end else begin
         col_nx = col_ff + RC_BITS'(1);
         row_nx = row_ff;
      end
      nb_ok[0]   = row_ff != '0;
      nb_ok[1]   = ({1'b0, row_ff} + SIDE_BITS'(1)) < side_ff;
      nb_ok[2]   = col_ff != '0;
      nb_ok[3]   = ({1'b0, col_ff} + SIDE_BITS'(1)) < side_ff;
      nb_addr[0] = me_ff - IDX_BITS'(side_ff);
      nb_addr[1] = me_ff + IDX_BITS'(side_ff);
      nb_addr[2] = me_ff - IDX_BITS'(1);
      nb_addr[3] = me_ff + IDX_BITS'(1);
   end

   // lowest neighbour and downhill mask
   always_comb begin
      have   = 1'b0;
      lowest = '0;
      for (int k = 0; k < 4; k++) begin
         if (nb_ok[k] && (!have || nbh_ff[k] < lowest)) begin
            lowest = nbh_ff[k];
            have   = 1'b1;
         end
      end
      for (int k = 0; k < 4; k++) begin
         new_mask[k] = have && (lowest < own_ff) && nb_ok[k] && (nbh_ff[k] == lowest);
      end
   end

   always_comb begin
      ua = '0;
      ub = '0;
      unique case (state_ff)
         ST_SW_RAIN: begin
            ua = wat_rd;
            ub = (step_ff <= STEP_BITS'(rain_ff)) ? ONE_Q : '0;
         end
         ST_SW_ABS: begin
            ua = absd_ff;
            ub = amt_ff;
         end
         ST_SW_TWR: begin
            ua = inf_rd;
            ub = WATER_BITS'(share_ff);
         end
         ST_MG_WR: begin
            ua = wat_rd;
            ub = inf_rd;
         end
         default: begin
            ua = '0;
            ub = '0;
         end
      endcase
   end

   grat_unit u_unit (
      .op_a (ua),
      .op_b (ub),
      .sum  (usum)
   );

   always_comb begin
      rate_ext = WATER_BITS'(rate_ff);
      amount   = (usum < rate_ext) ? usum : rate_ext;
      trk      = (wcur_ff < ONE_Q) ? wcur_ff[TRK_BITS-1:0] : ONE_T;
      cnt      = 3'(mask_ff[0]) + 3'(mask_ff[1]) + 3'(mask_ff[2]) + 3'(mask_ff[3]);
      prod     = (TRK_BITS+RECIP_BITS)'(trk_ff) * (TRK_BITS+RECIP_BITS)'(RECIP3);
      case (cnt)
         3'd2:    share = trk_ff >> 1;
         3'd3:    share = TRK_BITS'(prod >> RECIP_SH);
         3'd4:    share = trk_ff >> 2;
         default: share = trk_ff;
      endcase
   end

   // result completes this cycle and is registered for rsp_valid
   always_comb begin
      rsp_done = 1'b0;
      unique case (state_ff)
         ST_IDLE:  rsp_done = accept_in && (req_payload.opcode != OP_RUN)
                              && (req_payload.opcode != OP_READ);
         ST_RDOUT: rsp_done = 1'b1;
         ST_MG_WR: rsp_done = last_cell
                              && ((dry_ff && usum == '0) || step_ff == STEP_LIMIT);
         default:  rsp_done = 1'b0;
      endcase
   end

   // RAM port control
   always_comb begin
      ter_we = accept_in && (req_payload.opcode == OP_LOAD) && in_grid;
      ter_wa = req_payload.cell_index;
      ter_ra = (dk_ff == 3'd4) ? me_ff : nb_addr[dk_ff[1:0]];
      abs_ra = (state_ff == ST_IDLE) ? req_payload.cell_index : me_ff;
      inf_ra = (state_ff == ST_SW_TRD) ? nb_addr[tk_ff[1:0]] : me_ff;
      msk_we = state_ff == ST_DH_WR;
      wat_we = 1'b0;
      wat_wa = me_ff;
      wat_wd = '0;
      abs_we = 1'b0;
      abs_wa = me_ff;
      abs_wd = '0;
      inf_we = 1'b0;
      inf_wa = me_ff;
      inf_wd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wat_we = 1'b1;
            wat_wa = clr_ff;
            abs_we = 1'b1;
            abs_wa = clr_ff;
            inf_we = 1'b1;
            inf_wa = clr_ff;
         end
         ST_SW_ABS: begin
            wat_we = 1'b1;
            wat_wd = (mask_ff != '0) ? wcur_ff - WATER_BITS'(trk) : wcur_ff;
            abs_we = 1'b1;
            abs_wd = usum;
         end
         ST_SW_TWR: begin
            inf_we = 1'b1;
            inf_wa = nb_addr[tk_ff[1:0]];
            inf_wd = usum;
         end
         ST_MG_WR: begin
            wat_we = 1'b1;
            wat_wd = usum;
            inf_we = 1'b1;
         end
         default: begin
            wat_we = 1'b0;
         end
      endcase
   end

   grat_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_terrain (
      .clock (clock), .we (ter_we), .waddr (ter_wa), .wdata (req_payload.height),
      .raddr (ter_ra), .rdata (ter_rd)
   );
   grat_ram #(.WIDTH(WATER_BITS), .DEPTH(CELLS)) u_water (
      .clock (clock), .we (wat_we), .waddr (wat_wa), .wdata (wat_wd),
      .raddr (me_ff), .rdata (wat_rd)
   );
   grat_ram #(.WIDTH(WATER_BITS), .DEPTH(CELLS)) u_absorbed (
      .clock (clock), .we (abs_we), .waddr (abs_wa), .wdata (abs_wd),
      .raddr (abs_ra), .rdata (abs_rd)
   );
   grat_ram #(.WIDTH(WATER_BITS), .DEPTH(CELLS)) u_inflow (
      .clock (clock), .we (inf_we), .waddr (inf_wa), .wdata (inf_wd),
      .raddr (inf_ra), .rdata (inf_rd)
   );
   grat_ram #(.WIDTH(4), .DEPTH(CELLS)) u_mask (
      .clock (clock), .we (msk_we), .waddr (me_ff), .wdata (new_mask),
      .raddr (me_ff), .rdata (msk_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         side_cfg_ff <= SIDE_RST;
         rain_ff     <= RAIN_RST;
         rate_ff     <= RATE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIDE: side_cfg_ff <= csr_wdata[SIDE_BITS-1:0];
            CSR_RAIN: rain_ff     <= csr_wdata[RAIN_BITS-1:0];
            CSR_RATE: rate_ff     <= csr_wdata[RATE_BITS-1:0];
            default:  rate_ff     <= rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ran_ff       <= 1'b0;
         steps_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_done || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept_in) begin
                  rsp_ff.absorbed   <= '0;
                  rsp_ff.step_count <= steps_ff;
                  rsp_ff.status     <= (req_payload.opcode == OP_LOAD) && !in_grid;
                  inside_ff         <= in_grid;
                  unique case (req_payload.opcode)
                     OP_RUN: begin
                        side_ff  <= side_use;
                        cells_ff <= cells_use;
                        clr_ff   <= '0;
                        ran_ff   <= 1'b1;
                        state_ff <= ST_CLEAR;
                     end
                     OP_READ: state_ff <= ST_RDOUT;
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_RDOUT: begin
               rsp_ff.absorbed <= (inside_ff && ran_ff) ? abs_rd : '0;
               rsp_ff.status   <= !inside_ff;
               state_ff        <= ST_IDLE;
            end
            ST_CLEAR: begin
               clr_ff <= clr_ff + IDX_BITS'(1);
               if (clr_ff == IDX_BITS'(CELLS - 1)) begin
                  me_ff    <= '0;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  dk_ff    <= '0;
                  state_ff <= ST_DH_RD;
               end
            end
            ST_DH_RD: state_ff <= ST_DH_CAP;
            ST_DH_CAP: begin
               if (dk_ff == 3'd4) begin
                  own_ff   <= ter_rd;
                  state_ff <= ST_DH_WR;
               end else begin
                  nbh_ff[dk_ff[1:0]] <= ter_rd;
                  dk_ff              <= dk_ff + 3'd1;
                  state_ff           <= ST_DH_RD;
               end
            end
            ST_DH_WR: begin
               dk_ff <= '0;
               if (last_cell) begin
                  me_ff    <= '0;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  step_ff  <= STEP_BITS'(1);
                  state_ff <= ST_SW_RD;
               end else begin
                  me_ff    <= me_nx;
                  row_ff   <= row_nx;
                  col_ff   <= col_nx;
                  state_ff <= ST_DH_RD;
               end
            end
            ST_SW_RD: state_ff <= ST_SW_RAIN;
            ST_SW_RAIN: begin
               wcur_ff  <= usum - amount;
               amt_ff   <= amount;
               absd_ff  <= abs_rd;
               mask_ff  <= msk_rd;
               state_ff <= ST_SW_ABS;
            end
            ST_SW_ABS: begin
               trk_ff <= trk;
               tk_ff  <= '0;
               if (mask_ff != '0) begin
                  state_ff <= ST_SW_DIV;
               end else if (last_cell) begin
                  me_ff    <= '0;
                  dry_ff   <= 1'b1;
                  state_ff <= ST_MG_RD;
               end else begin
                  me_ff    <= me_nx;
                  row_ff   <= row_nx;
                  col_ff   <= col_nx;
                  state_ff <= ST_SW_RD;
               end
            end
            ST_SW_DIV: begin
               share_ff <= share;
               state_ff <= ST_SW_TRD;
            end
            ST_SW_TRD: begin
               if (tk_ff == 3'd4) begin
                  if (last_cell) begin
                     me_ff    <= '0;
                     dry_ff   <= 1'b1;
                     state_ff <= ST_MG_RD;
                  end else begin
                     me_ff    <= me_nx;
                     row_ff   <= row_nx;
                     col_ff   <= col_nx;
                     state_ff <= ST_SW_RD;
                  end
               end else if (mask_ff[tk_ff[1:0]]) begin
                  state_ff <= ST_SW_TWR;
               end else begin
                  tk_ff <= tk_ff + 3'd1;
               end
            end
            ST_SW_TWR: begin
               tk_ff    <= tk_ff + 3'd1;
               state_ff <= ST_SW_TRD;
            end
            ST_MG_RD: state_ff <= ST_MG_WR;
            ST_MG_WR: begin
               if (usum != '0) begin
                  dry_ff <= 1'b0;
               end
               if (last_cell) begin
                  if (rsp_done) begin
                     steps_ff          <= step_ff;
                     rsp_ff.absorbed   <= '0;
                     rsp_ff.step_count <= step_ff;
                     rsp_ff.status     <= 1'b0;
                     state_ff          <= ST_IDLE;
                  end else begin
                     step_ff  <= step_ff + STEP_BITS'(1);
                     me_ff    <= '0;
                     row_ff   <= '0;
                     col_ff   <= '0;
                     state_ff <= ST_SW_RD;
                  end
               end else begin
                  me_ff    <= me_nx;
                  state_ff <= ST_MG_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (accept_in && req_payload.opcode == OP_RUN) |=> state_ff == ST_CLEAR)
      else $error("run transfer did not start the clearing pass");
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SW_RD) |-> step_ff != '0)
      else $error("sweep with zero step count");
   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SW_RD || state_ff == ST_MG_RD || state_ff == ST_DH_RD)
      |-> ({1'b0, me_ff} < cells_ff))
      else $error("cell pointer beyond grid in use");
   a_trickle_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SW_TWR) |-> (mask_ff[tk_ff[1:0]] && nb_ok[tk_ff[1:0]]))
      else $error("trickle to a neighbour that is not downhill");
`endif
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the rainfall grid block: a directed table, then random
// load/run/read phases, checked against a model or fixed values. Uses grat_pkg.
module tb_top;
   import grat_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;
   localparam logic [19:0] STEP_SAT = 20'hFFFFF;
   localparam logic [31:0] WATER_ONE = 32'd65536;

   typedef struct {
      bit             is_csr;
      logic [1:0]     csr_idx;
      logic [20:0]    csr_val;
      req_type        req;
      bit             typed;
      rsp_type        want;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_we;
   req_type req_payload;
   rsp_type rsp_payload;
   logic [1:0] csr_index;
   logic [CSR_BITS-1:0] csr_wdata;

   grid_rainfall_absorb_trickle_sim u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // model state
   logic [5:0]  m_side = 6'd32;
   logic [15:0] m_rain = 16'd10;
   logic [20:0] m_rate = 21'd32768;
   logic [15:0] m_height [CELLS];
   logic [31:0] m_absorbed [CELLS];
   logic [31:0] m_water [CELLS];
   logic [31:0] m_inflow [CELLS];
   logic [3:0]  m_mask [CELLS];
   logic [19:0] m_steps = '0;

   rsp_type pending_rsp[$];
   row_t    plan[$];
   int      fails = 0;
   int      cycles = 0;
   bit      calm = 0;

   function automatic int side_used();
      if (m_side == 0) return 1;
      if (m_side > MAX_SIDE) return MAX_SIDE;
      return m_side;
   endfunction

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFFFFFF : s[31:0];
   endfunction

   // 0 up, 1 down, 2 left, 3 right; -1 where off the grid
   function automatic int nbr(int side, int r, int c, int k);
      case (k)
         0: if (r == 0) return -1; else return (r - 1) * side + c;
         1: if (r + 1 >= side) return -1; else return (r + 1) * side + c;
         2: if (c == 0) return -1; else return r * side + c - 1;
         default: if (c + 1 >= side) return -1; else return r * side + c + 1;
      endcase
   endfunction

   function automatic void simulate_rain();
      int side, me, nb, step;
      bit have, dry;
      logic [15:0] lowest;
      logic [31:0] w, a, t, share;
      side = side_used();
      for (int i = 0; i < CELLS; i++) begin
         m_water[i] = '0;
         m_absorbed[i] = '0;
      end
      for (int r = 0; r < side; r++)
         for (int c = 0; c < side; c++) begin
            me = r * side + c;
            have = 0;
            lowest = '0;
            m_mask[me] = '0;
            for (int k = 0; k < 4; k++) begin
               nb = nbr(side, r, c, k);
               if (nb >= 0 && (!have || m_height[nb] < lowest)) begin
                  lowest = m_height[nb];
                  have = 1;
               end
            end
            if (have && lowest < m_height[me])
               for (int k = 0; k < 4; k++) begin
                  nb = nbr(side, r, c, k);
                  if (nb >= 0 && m_height[nb] == lowest) m_mask[me][k] = 1'b1;
               end
         end
      step = 1;
      forever begin
         for (int i = 0; i < CELLS; i++) m_inflow[i] = '0;
         for (int r = 0; r < side; r++)
            for (int c = 0; c < side; c++) begin
               me = r * side + c;
               w = m_water[me];
               if (step <= m_rain) w = sat_sum(w, WATER_ONE);
               a = (w < 32'(m_rate)) ? w : 32'(m_rate);
               m_absorbed[me] = sat_sum(m_absorbed[me], a);
               w = w - a;
               if (m_mask[me] != 0) begin
                  t = (w < WATER_ONE) ? w : WATER_ONE;
                  w = w - t;
                  share = t / $countones(m_mask[me]);
                  for (int k = 0; k < 4; k++) begin
                     nb = nbr(side, r, c, k);
                     if (m_mask[me][k] && nb >= 0) m_inflow[nb] = sat_sum(m_inflow[nb], share);
                  end
               end
               m_water[me] = w;
            end
         dry = 1;
         for (int i = 0; i < side * side; i++) begin
            m_water[i] = sat_sum(m_water[i], m_inflow[i]);
            if (m_water[i] != 0) dry = 0;
         end
         if (dry || step >= STEP_SAT) break;
         step++;
      end
      m_steps = 20'(step);
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type p;
      bit in_grid;
      in_grid = r.cell_index < side_used() * side_used();
      p = '0;
      case (r.opcode)
         OP_LOAD: if (in_grid) m_height[r.cell_index] = r.height; else p.status = 1'b1;
         OP_RUN:  simulate_rain();
         OP_READ: if (in_grid) p.absorbed = m_absorbed[r.cell_index]; else p.status = 1'b1;
         default: ;
      endcase
      p.step_count = m_steps;
      return p;
   endfunction

   function automatic int pick_gap();
      int x;
      if (calm) return 0;
      x = $urandom_range(0, 99);
      if (x < 60) return 0;
      if (x < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(req_type r, bit typed, rsp_type want);
      rsp_type p;
      int gap;
      p = predict_rsp(r);
      if (typed) p = want;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      pending_rsp = {pending_rsp, p};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [20:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SIDE: m_side = val[5:0];
         CSR_RAIN: m_rain = val[15:0];
         CSR_RATE: m_rate = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type mk(logic [1:0] op, int idx, int h);
      req_type r;
      r.opcode = op;
      r.cell_index = 10'(idx);
      r.height = 16'(h);
      return r;
   endfunction

   function automatic void add_row(logic [1:0] op, int idx, int h, bit typed,
                                   logic [19:0] steps, bit st);
      row_t w;
      w = '{default: '0};
      w.req = mk(op, idx, h);
      w.typed = typed;
      w.want.absorbed = '0;
      w.want.step_count = steps;
      w.want.status = st;
      plan = {plan, w};
   endfunction

   function automatic void add_csr(logic [1:0] idx, logic [20:0] val);
      row_t w;
      w = '{default: '0};
      w.is_csr = 1;
      w.csr_idx = idx;
      w.csr_val = val;
      plan = {plan, w};
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transfer %h", $time, rsp_payload);
            fails++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_payload.absorbed !== e.absorbed) begin
               $display("%0t: absorbed exp %h got %h", $time, e.absorbed, rsp_payload.absorbed);
               fails++;
            end
            if (rsp_payload.step_count !== e.step_count) begin
               $display("%0t: step_count exp %h got %h", $time, e.step_count,
                        rsp_payload.step_count);
               fails++;
            end
            if (rsp_payload.status !== e.status) begin
               $display("%0t: status exp %b got %b", $time, e.status, rsp_payload.status);
               fails++;
            end
         end
      end
   end

   // receiver back-pressure
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm) begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3: hold = $urandom_range(1, 3);
                  4: hold = $urandom_range(15, 50);
                  default: hold = 0;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int n, count, mode;
      rsp_type none;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      none = '0;
      for (int i = 0; i < CELLS; i++) begin
         m_height[i] = '0;
         m_absorbed[i] = '0;
         m_water[i] = '0;
         m_inflow[i] = '0;
         m_mask[i] = '0;
      end

      add_row(OP_READ, 0, 0, 1, 0, 0);
      add_row(OP_READ, 1023, 0, 1, 0, 0);
      add_row(2'd3, 1023, 16'hFFFF, 1, 0, 0);
      add_row(OP_LOAD, 1023, 16'hFFFF, 1, 0, 0);
      add_row(OP_LOAD, 0, 0, 1, 0, 0);
      add_csr(CSR_SIDE, 21'h1FFFFF);
      add_row(OP_READ, 1023, 0, 1, 0, 0);
      add_csr(CSR_SIDE, 21'd0);
      add_row(OP_LOAD, 1, 5, 1, 0, 1);
      add_row(OP_READ, 1023, 0, 1, 0, 1);
      add_row(OP_LOAD, 0, 7, 1, 0, 0);
      add_row(OP_RUN, 0, 0, 0, 0, 0);
      add_row(OP_READ, 0, 0, 0, 0, 0);
      add_csr(CSR_RAIN, 21'd0);
      add_csr(CSR_RATE, 21'd1);
      add_row(OP_RUN, 0, 0, 1, 1, 0);
      add_row(OP_READ, 0, 0, 1, 1, 0);
      add_csr(CSR_SIDE, 21'd2);
      add_csr(CSR_RAIN, 21'd3);
      add_csr(CSR_RATE, 21'd1048576);
      add_row(OP_LOAD, 0, 9, 0, 0, 0);
      add_row(OP_LOAD, 1, 4, 0, 0, 0);
      add_row(OP_LOAD, 2, 4, 0, 0, 0);
      add_row(OP_LOAD, 3, 0, 0, 0, 0);
      add_row(OP_RUN, 0, 0, 0, 0, 0);
      add_row(OP_READ, 3, 0, 0, 0, 0);
      add_row(OP_READ, 0, 0, 0, 0, 0);
      add_csr(CSR_RAIN, 21'h1FFFFF);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_csr(plan[i].csr_idx, plan[i].csr_val);
         else send_item(plan[i].req, plan[i].typed, plan[i].want);
      end

      count = 0;
      while (count < 110) begin
         write_csr(CSR_SIDE, ($urandom_range(0, 9) == 0) ? 21'd1 : 21'($urandom_range(2, 5)));
         write_csr(CSR_RAIN, 21'($urandom_range(0, 8)));
         write_csr(CSR_RATE, ($urandom_range(0, 3) == 0) ? 21'd1048576
                                                         : 21'($urandom_range(32768, 131072)));
         calm = ($urandom_range(0, 3) == 0);
         n = side_used() * side_used();
         mode = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) begin
            case (mode)
               0: send_item(mk(OP_LOAD, i, $urandom_range(0, 3)), 0, none);
               1: send_item(mk(OP_LOAD, i, $urandom_range(0, 65535)), 0, none);
               default: send_item(mk(OP_LOAD, i, $urandom_range(0, 1) ? 16'hFFFF : 0), 0, none);
            endcase
            count++;
         end
         repeat ($urandom_range(1, 4)) begin
            send_item(mk(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                         $urandom_range(0, 65535)), 0, none);
            count++;
         end
         send_item(mk(OP_RUN, $urandom_range(0, 1023), $urandom_range(0, 65535)), 0, none);
         count++;
         repeat ($urandom_range(3, 8)) begin
            send_item(mk(OP_READ, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                            : $urandom_range(0, n - 1), 0),
                      0, none);
            count++;
         end
      end

      calm = 0;
      drain();
      repeat (20) @(posedge clock);
      if (fails == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
